// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- hdl/lpoc_pkg.sv -----
// ----------------------------------------------------------------------------
// Occurrence counter package
// Field widths, codes, state encoding and controller/datapath bundles.
// ----------------------------------------------------------------------------
package lpoc_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned SLOT_W      = 10;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - CNT_W - SLOT_W - 1;

  localparam logic [CNT_W-1:0] COUNT_MAX    = 8'd255;
  localparam logic [CNT_W-1:0] REPEAT_SET   = 8'd3;
  localparam logic [CNT_W-1:0] REPEAT_CLEAR = 8'd2;

  // Key bits folded into the remainder per cycle by the home slot divider.
  localparam int unsigned HASH_STEP = 4;

  typedef enum logic [FUNC_W-1:0] {
    FN_RECORD = 2'd0,
    FN_REMOVE = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_NOP    = 2'd3
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_MISSING   = 2'd2,
    STAT_UNDERFLOW = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CMP,
    S_CLEAR,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic load_home;
    logic probe_next;
    logic resolve;
    logic sweep;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic hit;
    logic last_probe;
    logic sweep_last;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/lpoc_hash.sv -----
// ----------------------------------------------------------------------------
// Home slot unit
// Reduces a key modulo the table depth: a bit mask for power-of-two depths,
// otherwise a restoring remainder that folds a few key bits per cycle.
// ----------------------------------------------------------------------------
module lpoc_hash
  import lpoc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [IDX_W-1:0] home_o
);

  localparam bit POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  logic [KEY_W-1:0] key_q;

  if (POW2) begin : g_mask
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        key_q <= '0;
      end else if (start_i) begin
        key_q <= key_i;
      end
    end

    assign home_o = key_q[IDX_W-1:0];
    assign done_o = 1'b1;
  end else begin : g_div
    localparam int unsigned R_W        = IDX_W + 1;
    localparam int unsigned STEPS      = KEY_W / HASH_STEP;
    localparam int unsigned STEP_CNT_W = $clog2(STEPS);
    localparam logic [R_W-1:0] DIVISOR = R_W'(TABLE_DEPTH);

    logic [IDX_W-1:0]      rem_q, rem_d;
    logic [R_W-1:0]        acc;
    logic [STEP_CNT_W-1:0] step_q;
    logic                  busy_q;

    // The remainder stays below the depth, so each shifted value is below
    // twice the depth and one compare and subtract restores it.
    always_comb begin
      acc   = '0;
      rem_d = rem_q;
      for (int j = 0; j < HASH_STEP; j++) begin
        acc = {rem_d, key_q[KEY_W-1-j]};
        if (acc >= DIVISOR) begin
          acc = acc - DIVISOR;
        end
        rem_d = acc[IDX_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        step_q <= '0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_CNT_W'(1);
        if (step_q == STEP_CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
        rem_q <= '0;
      end else if (busy_q) begin
        key_q <= key_q << HASH_STEP;
        rem_q <= rem_d;
      end
    end

    assign home_o = rem_q;
    assign done_o = !busy_q;
  end

endmodule

// ----- hdl/lpoc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Occurrence counter controller
// Sequences the clearing sweep, home slot reduction, probing and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpoc_ctrl
  import lpoc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  input  func_e s_func_i,
  output logic  s_ready_o,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  state_e state_q, state_d;
  logic   probe_end;

  assign probe_end = stat_i.hit || stat_i.last_probe;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_valid_i) begin
          case (s_func_i)
            FN_RECORD: state_d = S_HASH;
            FN_REMOVE: state_d = S_HASH;
            FN_CLEAR:  state_d = S_CLEAR;
            default:   state_d = S_FINISH;
          endcase
        end
      end
      S_HASH: begin
        if (stat_i.hash_done) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        state_d = probe_end ? S_FINISH : S_READ;
      end
      S_CLEAR: begin
        if (stat_i.sweep_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    s_ready_o        = (state_q == S_IDLE);
    cmd_o            = '0;
    cmd_o.latch_in   = (state_q == S_IDLE) && s_valid_i;
    cmd_o.load_home  = (state_q == S_HASH) && stat_i.hash_done;
    cmd_o.probe_next = (state_q == S_CMP) && !probe_end;
    cmd_o.resolve    = (state_q == S_CMP) && probe_end;
    cmd_o.sweep      = (state_q == S_INIT) || (state_q == S_CLEAR);
    cmd_o.load_out   = (state_q == S_FINISH) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_PROP(a_out_slot_free, cmd_o.load_out |-> stat_i.out_free, "result loaded over a pending one")
  `ASSERT_PROP(a_cmp_exit, (state_q == S_CMP) |=> (state_q == S_FINISH || state_q == S_READ), "bad exit from compare")
  `ASSERT_PROP(a_resolve_finish, cmd_o.resolve |=> (state_q == S_FINISH), "resolve not followed by finish")

endmodule

// ----- hdl/lpoc_datapath.sv -----
// ----------------------------------------------------------------------------
// Occurrence counter datapath
// Slot memory, probe pointer, count update, sticky flag and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpoc_datapath
  import lpoc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  func_e                  s_func_i,
  input  logic [KEY_W-1:0]       s_key_i,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [OUT_TDATA_W-1:0] m_data_o,
  output logic [STAT_W-1:0]      m_user_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRY_W = CNT_W + KEY_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(TABLE_DEPTH);

  // Each entry holds the count above the key.
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_we;

  func_e            func_q;
  logic [KEY_W-1:0] key_q;
  logic [IDX_W-1:0] ptr_q, probes_q, next_ptr, home;
  logic             hash_done;

  logic [KEY_W-1:0] rd_key;
  logic [CNT_W-1:0] rd_cnt, inc_cnt, dec_cnt, new_cnt;
  logic             key_match, hit, underflow, commit, last_probe;

  stat_e             res_status_q;
  logic [CNT_W-1:0]  res_occ_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              flag_q;

  logic              out_valid_q;
  stat_e             out_status_q;
  logic [CNT_W-1:0]  out_occ_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_flag_q;

  lpoc_hash #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.latch_in),
    .key_i  (s_key_i),
    .done_o (hash_done),
    .home_o (home)
  );

  assign rd_key    = rd_q[KEY_W-1:0];
  assign rd_cnt    = rd_q[ENTRY_W-1:KEY_W];
  assign key_match = (rd_key == key_q);
  // A record may also claim any empty slot; a remove needs the key itself.
  assign hit       = (func_q == FN_RECORD) ? (key_match || (rd_cnt == '0)) : key_match;
  assign inc_cnt   = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + CNT_W'(1);
  assign dec_cnt   = rd_cnt - CNT_W'(1);
  assign new_cnt   = (func_q == FN_RECORD) ? inc_cnt : dec_cnt;
  assign underflow = (func_q == FN_REMOVE) && (rd_cnt == '0);
  assign commit    = cmd_i.resolve && hit && !underflow;

  assign next_ptr   = (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
  assign last_probe = (probes_q == LAST_IDX);

  assign mem_we    = cmd_i.sweep || commit;
  assign mem_wdata = cmd_i.sweep ? '0 : {new_cnt, key_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ptr_q] <= mem_wdata;
    end
    rd_q <= mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      func_q <= s_func_i;
      key_q  <= s_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      probes_q <= '0;
    end else if (cmd_i.latch_in) begin
      ptr_q    <= '0;
      probes_q <= '0;
    end else if (cmd_i.load_home) begin
      ptr_q    <= home;
      probes_q <= '0;
    end else if (cmd_i.probe_next || cmd_i.sweep) begin
      ptr_q    <= next_ptr;
      probes_q <= probes_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (cmd_i.sweep) begin
      flag_q <= 1'b0;
    end else if (commit) begin
      if ((func_q == FN_RECORD) && (new_cnt >= REPEAT_SET)) begin
        flag_q <= 1'b1;
      end else if ((func_q == FN_REMOVE) && (new_cnt == REPEAT_CLEAR)) begin
        flag_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      res_status_q <= STAT_OK;
      res_occ_q    <= '0;
      res_slot_q   <= '0;
    end else if (cmd_i.resolve) begin
      if (!hit) begin
        res_status_q <= (func_q == FN_RECORD) ? STAT_FULL : STAT_MISSING;
        res_occ_q    <= '0;
        res_slot_q   <= '0;
      end else if (underflow) begin
        res_status_q <= STAT_UNDERFLOW;
        res_occ_q    <= '0;
        res_slot_q   <= SLOT_W'(ptr_q);
      end else begin
        res_status_q <= STAT_OK;
        res_occ_q    <= new_cnt;
        res_slot_q   <= SLOT_W'(ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_occ_q    <= res_occ_q;
      out_slot_q   <= res_slot_q;
      out_flag_q   <= flag_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {OUT_PAD_W'(0), out_flag_q, out_slot_q, out_occ_q};
  assign m_user_o  = out_status_q;

  always_comb begin
    stat_o            = '0;
    stat_o.hash_done  = hash_done;
    stat_o.hit        = hit;
    stat_o.last_probe = last_probe;
    stat_o.sweep_last = (ptr_q == LAST_IDX);
    stat_o.out_free   = !out_valid_q || m_ready_i;
  end

  `ASSERT_PROP(a_home_in_range, cmd_i.load_home |-> ({1'b0, home} < DEPTH_EXT), "home slot outside table")
  `ASSERT_NEVER(a_one_pass, cmd_i.probe_next && last_probe, "probe ran past one full pass")
  `ASSERT_PROP(a_flag_set, (commit && func_q == FN_RECORD && new_cnt >= REPEAT_SET) |=> flag_q, "repeat flag not set")

endmodule

// ----- hdl/linear_probe_occurrence_counter_unit.sv -----
// ----------------------------------------------------------------------------
// Linear probe occurrence counter
// Hash table of 64-bit keys with saturating 8-bit counts and a repeat flag.
// ----------------------------------------------------------------------------
// The block keeps TABLE_DEPTH slots of {count, key} in one single-port memory
// and handles one transaction at a time. A record (func 0) probes from slot
// key mod TABLE_DEPTH for the key or an empty slot and bumps its count, which
// saturates at 255; the sticky thrice_seen flag rises once any count reaches
// three. A remove (func 1) probes for the key and decrements its count, and
// the flag drops when that count falls to two. A clear (func 2) zeroes the
// table and the flag; func 3 only reports the flag. Probing stops after one
// full pass and then reports table full or not found. A record or remove
// first reduces the key to its home slot (a bit mask for a power-of-two
// depth, otherwise a remainder that folds four key bits per step) and loads
// it into the probe pointer, then does one memory read and one compare per
// slot probed, and then hands its result to the output register. A clear
// zeroes every slot in turn. After reset the block sweeps the memory to zero
// with s_axis_tready low. A finished result sits in an output register, so
// the next transaction is accepted while it waits.
module linear_probe_occurrence_counter_unit
  import lpoc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [KEY_W-1:0]       s_axis_tdata,   // [63:0] position_key
  input  logic [FUNC_W-1:0]      s_axis_tuser,   // [1:0] func
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] occurrences, [17:8] slot_index,
                                                 // [18] thrice_seen, [23:19] zero
  output logic [STAT_W-1:0]      m_axis_tuser    // [1:0] status
);

  cmd_t  cmd;
  stat_t stat;
  func_e s_func;

  assign s_func = func_e'(s_axis_tuser);

  lpoc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_func_i (s_func),
    .s_ready_o(s_axis_tready),
    .cmd_o    (cmd),
    .stat_i   (stat)
  );

  lpoc_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .s_func_i (s_func),
    .s_key_i  (s_axis_tdata),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_data_o (m_axis_tdata),
    .m_user_o (m_axis_tuser)
  );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// Occurrence counter testbench
// Drives record, remove, clear and idle transactions into the hash counter and
// checks every result against a behavioral mirror of the table or a directed row.
// ----------------------------------------------------------------------------
// A short table of directed transactions opens the run, followed by random
// churn on a small set of colliding keys, a saturation run on one key, a full
// table fill with overflow probes, and more churn. The sender idles in bursts
// and the receiver stalls on its own pattern. A watchdog ends a run that stops
// moving.
module testbench;
  import lpoc_pkg::*;

  localparam int unsigned TB_DEPTH       = 1024;
  localparam int unsigned ITEM_TARGET    = 1750;
  localparam int unsigned HOT_KEYS       = 16;
  localparam int unsigned DRILL_ROWS     = 20;
  localparam int unsigned WATCHDOG_LIMIT = 6 * (2 * TB_DEPTH + 64);
  localparam int unsigned DRAIN_CYCLES   = 2 * TB_DEPTH + 16;

  localparam logic [KEY_W-1:0] KEY_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_ALIAS = 64'hFFFF_FFFF_FFFF_FBFF;
  localparam logic [KEY_W-1:0] KEY_MID   = 64'h8000_0000_0000_0200;

  typedef struct packed {
    stat_e             status;
    logic [CNT_W-1:0]  occ;
    logic [SLOT_W-1:0] slot;
    logic              flag;
  } outcome_t;

  typedef struct packed {
    func_e            op;
    logic [KEY_W-1:0] key;
    logic             known;
    outcome_t         want;
  } drill_row_t;

  localparam outcome_t NO_WANT = '0;

  // Rows with known set carry a result read straight off the spec; the rest
  // are checked against the mirror.
  localparam drill_row_t DRILL_TABLE [DRILL_ROWS] = '{
    '{FN_REMOVE, 64'h0,     1'b1, '{STAT_UNDERFLOW, 8'd0, 10'd0, 1'b0}},
    '{FN_REMOVE, 64'h5,     1'b1, '{STAT_MISSING, 8'd0, 10'd0, 1'b0}},
    '{FN_RECORD, KEY_ONES,  1'b1, '{STAT_OK, 8'd1, 10'd1023, 1'b0}},
    '{FN_RECORD, KEY_ONES,  1'b1, '{STAT_OK, 8'd2, 10'd1023, 1'b0}},
    '{FN_RECORD, KEY_ONES,  1'b1, '{STAT_OK, 8'd3, 10'd1023, 1'b1}},
    '{FN_REMOVE, KEY_ONES,  1'b1, '{STAT_OK, 8'd2, 10'd1023, 1'b0}},
    '{FN_RECORD, KEY_ALIAS, 1'b0, NO_WANT},
    '{FN_REMOVE, KEY_ALIAS, 1'b0, NO_WANT},
    '{FN_REMOVE, KEY_ALIAS, 1'b0, NO_WANT},
    '{FN_RECORD, 64'h0,     1'b0, NO_WANT},
    '{FN_NOP,    KEY_MID,   1'b0, NO_WANT},
    '{FN_RECORD, KEY_MID,   1'b1, '{STAT_OK, 8'd1, 10'd512, 1'b0}},
    '{FN_REMOVE, KEY_MID,   1'b1, '{STAT_OK, 8'd0, 10'd512, 1'b0}},
    '{FN_REMOVE, KEY_MID,   1'b1, '{STAT_UNDERFLOW, 8'd0, 10'd512, 1'b0}},
    '{FN_RECORD, KEY_ONES,  1'b0, NO_WANT},
    '{FN_NOP,    KEY_ONES,  1'b0, NO_WANT},
    '{FN_CLEAR,  64'h0123_4567_89AB_CDEF, 1'b1, '{STAT_OK, 8'd0, 10'd0, 1'b0}},
    '{FN_REMOVE, KEY_ONES,  1'b1, '{STAT_MISSING, 8'd0, 10'd0, 1'b0}},
    '{FN_NOP,    64'h0,     1'b1, '{STAT_OK, 8'd0, 10'd0, 1'b0}},
    '{FN_RECORD, 64'h3FF,   1'b0, NO_WANT}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [KEY_W-1:0]       s_axis_tdata = '0;
  logic [FUNC_W-1:0]      s_axis_tuser = FN_RECORD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;

  // Mirror of the table state.
  logic [KEY_W-1:0] mirror_keys [TB_DEPTH];
  logic [CNT_W-1:0] mirror_counts [TB_DEPTH];
  logic             mirror_repeat;

  outcome_t    pending_outcomes [$];
  int unsigned sent_count = 0;
  int unsigned result_count = 0;
  int unsigned error_count = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_run_left = 0;
  logic [KEY_W-1:0] fill_keys [TB_DEPTH];

  linear_probe_occurrence_counter_unit #(
    .TABLE_DEPTH(TB_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void wipe_mirror();
    foreach (mirror_keys[i]) begin
      mirror_keys[i]   = '0;
      mirror_counts[i] = '0;
    end
    mirror_repeat = 1'b0;
  endfunction

  // Applies one transaction to the mirror and returns the result it should give.
  function automatic outcome_t predict_outcome(func_e op, logic [KEY_W-1:0] key);
    outcome_t    res;
    int unsigned pos;
    logic        found;
    res   = '0;
    pos   = 32'(key % TB_DEPTH);
    found = 1'b0;
    case (op)
      FN_RECORD: begin
        // Stop at the key itself or at the first slot with a zero count.
        for (int n = 0; n < TB_DEPTH; n++) begin
          if (mirror_keys[pos] == key || mirror_counts[pos] == '0) begin
            found = 1'b1;
            break;
          end
          pos = (pos == TB_DEPTH - 1) ? 0 : pos + 1;
        end
        if (found) begin
          if (mirror_counts[pos] != COUNT_MAX) mirror_counts[pos] = mirror_counts[pos] + 8'd1;
          mirror_keys[pos] = key;
          if (mirror_counts[pos] >= REPEAT_SET) mirror_repeat = 1'b1;
          res.occ  = mirror_counts[pos];
          res.slot = pos[SLOT_W-1:0];
        end else begin
          res.status = STAT_FULL;
        end
      end
      FN_REMOVE: begin
        // A remove matches on the key alone, whatever the count.
        for (int n = 0; n < TB_DEPTH; n++) begin
          if (mirror_keys[pos] == key) begin
            found = 1'b1;
            break;
          end
          pos = (pos == TB_DEPTH - 1) ? 0 : pos + 1;
        end
        if (!found) begin
          res.status = STAT_MISSING;
        end else if (mirror_counts[pos] == '0) begin
          res.status = STAT_UNDERFLOW;
          res.slot   = pos[SLOT_W-1:0];
        end else begin
          mirror_counts[pos] = mirror_counts[pos] - 8'd1;
          if (mirror_counts[pos] == REPEAT_CLEAR) mirror_repeat = 1'b0;
          res.occ  = mirror_counts[pos];
          res.slot = pos[SLOT_W-1:0];
        end
      end
      FN_CLEAR: wipe_mirror();
      default: ;
    endcase
    res.flag = mirror_repeat;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at result %0d: %s", result_count, msg);
    error_count++;
  endtask

  // Offers one transaction, idling first when the current burst is used up.
  task automatic send_item(func_e op, logic [KEY_W-1:0] key, logic known, outcome_t want);
    outcome_t    model;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model = predict_outcome(op, key);
    pending_outcomes.insert(pending_outcomes.size(), known ? want : model);
    burst_left--;
    sent_count++;
  endtask

  // Random traffic on HOT_KEYS keys, most sharing home slots near both table ends,
  // so probes collide and wrap, with some fresh keys, idle codes and clears.
  task automatic churn(int unsigned stop_at);
    logic [KEY_W-1:0] hot_keys [HOT_KEYS];
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    for (int i = 0; i < HOT_KEYS; i++) begin
      hot_keys[i] = rand_key();
      case ($urandom_range(0, 4))
        0: hot_keys[i][SLOT_W-1:0] = '0;
        1: hot_keys[i][SLOT_W-1:0] = 10'd1;
        2: hot_keys[i][SLOT_W-1:0] = 10'(TB_DEPTH - 2);
        3: hot_keys[i][SLOT_W-1:0] = 10'(TB_DEPTH - 1);
        default: ;
      endcase
    end
    hot_keys[0] = '0;
    hot_keys[1] = KEY_ONES;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      key  = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
      if (pick < 50)      send_item(FN_RECORD, key, 1'b0, NO_WANT);
      else if (pick < 80) send_item(FN_REMOVE, key, 1'b0, NO_WANT);
      else if (pick < 84) send_item(FN_REMOVE, rand_key(), 1'b0, NO_WANT);
      else if (pick < 90) send_item(FN_RECORD, rand_key(), 1'b0, NO_WANT);
      else if (pick < 97) send_item(FN_NOP, rand_key(), 1'b0, NO_WANT);
      else                send_item(FN_CLEAR, rand_key(), 1'b0, NO_WANT);
    end
  endtask

  task automatic check_result();
    outcome_t want;
    if (pending_outcomes.size() == 0) begin
      report_mismatch($sformatf("unexpected result, tuser %0d tdata %h",
                                m_axis_tuser, m_axis_tdata));
      return;
    end
    want = pending_outcomes.pop_front();
    if (m_axis_tuser !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, want.status));
    if (m_axis_tdata[7:0] !== want.occ)
      report_mismatch($sformatf("occurrences %0d, expected %0d", m_axis_tdata[7:0], want.occ));
    if (m_axis_tdata[17:8] !== want.slot)
      report_mismatch($sformatf("slot_index %0d, expected %0d", m_axis_tdata[17:8], want.slot));
    if (m_axis_tdata[18] !== want.flag)
      report_mismatch($sformatf("thrice_seen %0b, expected %0b", m_axis_tdata[18], want.flag));
    if (m_axis_tdata[OUT_TDATA_W-1:19] !== '0)
      report_mismatch($sformatf("padding bits %h not zero", m_axis_tdata[OUT_TDATA_W-1:19]));
    result_count++;
  endtask

  // Receiver: alternating ready and stall runs, with long stretches of ready.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result();
    if (rx_run_left == 0) begin
      if (m_axis_tready) begin
        m_axis_tready <= 1'b0;
        rx_run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 24)
                                                     : $urandom_range(1, 4);
      end else begin
        m_axis_tready <= 1'b1;
        rx_run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 12);
      end
    end else begin
      rx_run_left--;
    end
  end

  // Watchdog on cycles without any transaction on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("linear_probe_occurrence_counter_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0] key;
    wipe_mirror();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DRILL_ROWS; r++)
      send_item(DRILL_TABLE[r].op, DRILL_TABLE[r].key, DRILL_TABLE[r].known,
                DRILL_TABLE[r].want);

    churn(sent_count + 300);

    // Drive one key to saturation, then remove it four times, staying above the flag threshold.
    send_item(FN_CLEAR, rand_key(), 1'b0, NO_WANT);
    key = rand_key();
    for (int i = 0; i < 260; i++) send_item(FN_RECORD, key, 1'b0, NO_WANT);
    for (int i = 0; i < 4; i++) send_item(FN_REMOVE, key, 1'b0, NO_WANT);

    // Fill every slot, then probe the full table.
    send_item(FN_CLEAR, rand_key(), 1'b0, NO_WANT);
    for (int i = 0; i < TB_DEPTH; i++) begin
      fill_keys[i] = rand_key();
      fill_keys[i][SLOT_W-1:0] = SLOT_W'(i);
      send_item(FN_RECORD, fill_keys[i], 1'b0, NO_WANT);
    end
    for (int i = 0; i < 3; i++) send_item(FN_RECORD, rand_key(), 1'b0, NO_WANT);
    send_item(FN_RECORD, fill_keys[7], 1'b0, NO_WANT);
    send_item(FN_REMOVE, fill_keys[9], 1'b0, NO_WANT);
    send_item(FN_REMOVE, fill_keys[9], 1'b0, NO_WANT);
    send_item(FN_RECORD, rand_key(), 1'b0, NO_WANT);
    for (int i = 0; i < 2; i++) send_item(FN_REMOVE, rand_key(), 1'b0, NO_WANT);
    send_item(FN_CLEAR, rand_key(), 1'b0, NO_WANT);

    churn(ITEM_TARGET);
    s_axis_tvalid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("linear_probe_occurrence_counter_unit regression: pass");
    end else begin
      $display("linear_probe_occurrence_counter_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/lpoc_pkg.sv
hdl/lpoc_hash.sv
hdl/lpoc_ctrl.sv
hdl/lpoc_datapath.sv
hdl/linear_probe_occurrence_counter_unit.sv
sim/testbench.sv
